// File: sv/eds_pkg.sv
// Shared types and constants of the elevator disk request scheduler.
`default_nettype none

package eds_pkg;

    // Default depth of the request chain
    localparam int MAX_REQUESTS = 16;

    // Field widths
    localparam int CYL_W  = 16;
    localparam int MOVE_W = 24;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // Register reset values
    localparam logic [CYL_W-1:0]  TOP_RESET    = 16'd499;
    localparam logic [CYL_W-1:0]  BOTTOM_RESET = 16'd0;
    localparam logic [MODE_W-1:0] MODE_RESET   = 2'd0;

    // Sweep modes; the unused code sweeps as LOOK
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SWEEP_MODE      = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TOP_CYLINDER    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BOTTOM_CYLINDER = 2'd2;

    // One stored request; the down bit sorts the lower requests behind the upper ones
    typedef struct packed {
        logic             down;
        logic [CYL_W-1:0] cyl;
    } entry_t;

    // Chain operations
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP_FRONT,
        OP_POP_BACK
    } op_t;

    // Command broadcast to every cell
    typedef struct packed {
        op_t    op;
        entry_t entry;
    } chain_cmd_t;

    // Chain status seen by the sequencer
    typedef struct packed {
        entry_t front;
        entry_t back;
        logic   front_valid;
        logic   second_valid;
        logic   full;
    } chain_stat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_UP,
        ST_TOP,
        ST_BOTTOM,
        ST_DOWN
    } state_t;

endpackage

`default_nettype wire

// File: sv/eds_cell.sv
// One cell of the sorted request chain.
`default_nettype none

module eds_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire eds_pkg::chain_cmd_t  cmd,
    input  wire eds_pkg::entry_t      left_entry,
    input  wire logic                 left_valid,
    input  wire logic                 left_greater,
    input  wire eds_pkg::entry_t      right_entry,
    input  wire logic                 right_valid,
    output eds_pkg::entry_t           entry,
    output logic                      valid,
    output logic                      greater
);

    eds_pkg::entry_t entry_reg;
    eds_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    // An empty cell ranks above any new word
    assign greater = !valid_reg || (entry_reg > cmd.entry);
    assign entry   = entry_reg;
    assign valid   = valid_reg;

    // Insert, shift toward the front, or drop the tail
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (cmd.op)
            eds_pkg::OP_INSERT:
            begin
                if (greater)
                begin
                    if (left_greater)
                    begin
                        entry_next = left_entry;
                        valid_next = left_valid;
                    end
                    else
                    begin
                        entry_next = cmd.entry;
                        valid_next = 1'b1;
                    end
                end
            end
            eds_pkg::OP_POP_FRONT:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            eds_pkg::OP_POP_BACK:
            begin
                valid_next = valid_reg && right_valid;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// File: sv/eds_chain.sv
// Row of cells that keeps the pending requests sorted.
`default_nettype none

module eds_chain
#(
    parameter int MAX_REQUESTS = eds_pkg::MAX_REQUESTS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire eds_pkg::chain_cmd_t  cmd,
    output eds_pkg::chain_stat_t      stat
);

    eds_pkg::entry_t entry_w   [MAX_REQUESTS];
    logic            valid_w   [MAX_REQUESTS];
    logic            greater_w [MAX_REQUESTS];
    logic            tail_w    [MAX_REQUESTS];
    eds_pkg::entry_t back;

    genvar i;
    generate
        for (i = 0; i < MAX_REQUESTS; i++)
        begin : g_cell
            eds_pkg::entry_t left_entry;
            logic            left_valid;
            logic            left_greater;
            eds_pkg::entry_t right_entry;
            logic            right_valid;

            // Tie off the ends of the row
            if (i == 0)
            begin : g_head
                assign left_entry   = '0;
                assign left_valid   = 1'b0;
                assign left_greater = 1'b0;
            end
            else
            begin : g_mid_left
                assign left_entry   = entry_w[i-1];
                assign left_valid   = valid_w[i-1];
                assign left_greater = greater_w[i-1];
            end

            if (i == MAX_REQUESTS - 1)
            begin : g_tail
                assign right_entry = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_mid_right
                assign right_entry = entry_w[i+1];
                assign right_valid = valid_w[i+1];
            end

            // Mark the last occupied cell
            assign tail_w[i] = valid_w[i] && !right_valid;

            eds_cell u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .left_entry   (left_entry),
                .left_valid   (left_valid),
                .left_greater (left_greater),
                .right_entry  (right_entry),
                .right_valid  (right_valid),
                .entry        (entry_w[i]),
                .valid        (valid_w[i]),
                .greater      (greater_w[i])
            );
        end

        if (MAX_REQUESTS > 1)
        begin : g_second
            assign stat.second_valid = valid_w[1];
        end
        else
        begin : g_single
            assign stat.second_valid = 1'b0;
        end
    endgenerate

    // Select the tail word
    always_comb
    begin
        back = '0;
        for (int k = 0; k < MAX_REQUESTS; k++)
        begin
            back = back | (tail_w[k] ? entry_w[k] : '0);
        end
    end

    assign stat.front       = entry_w[0];
    assign stat.front_valid = valid_w[0];
    assign stat.back        = back;
    assign stat.full        = valid_w[MAX_REQUESTS-1];

endmodule

`default_nettype wire

// File: sv/eds_seq.sv
// Sequencer: loads a batch, walks the chain in sweep order, tracks head movement.
`default_nettype none

module eds_seq
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [eds_pkg::CYL_W-1:0]       head_position,
    input  wire logic [eds_pkg::CYL_W-1:0]       request_cylinder,
    input  wire logic                            last_request,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [eds_pkg::CYL_W-1:0]            visit_cylinder,
    output logic [eds_pkg::MOVE_W-1:0]           total_movement,
    output logic                                 is_endpoint,
    output logic                                 last_visit,
    input  wire logic [eds_pkg::MODE_W-1:0]      sweep_mode,
    input  wire logic [eds_pkg::CYL_W-1:0]       top_cylinder,
    input  wire logic [eds_pkg::CYL_W-1:0]       bottom_cylinder,
    input  wire eds_pkg::chain_stat_t            stat,
    output eds_pkg::chain_cmd_t                  cmd
);

    eds_pkg::state_t              state_reg;
    eds_pkg::state_t              state_next;
    logic [eds_pkg::CYL_W-1:0]    start_head_reg;
    logic [eds_pkg::CYL_W-1:0]    head_now_reg;
    logic [eds_pkg::CYL_W-1:0]    head_now_next;
    logic [eds_pkg::MOVE_W-1:0]   sum_reg;
    logic [eds_pkg::MOVE_W-1:0]   sum_next;
    logic                         out_valid_reg;
    logic [eds_pkg::CYL_W-1:0]    out_cyl_reg;
    logic [eds_pkg::MOVE_W-1:0]   out_sum_reg;
    logic                         out_end_reg;
    logic                         out_last_reg;

    logic                         accept;
    logic                         close;
    logic                         emit_ok;
    logic                         front_up;
    logic                         mode_scan;
    logic                         mode_cscan;
    logic                         mode_look;
    logic [eds_pkg::CYL_W-1:0]    head_eff;
    logic                         emit;
    logic [eds_pkg::CYL_W-1:0]    vis_cyl;
    logic                         vis_end;
    logic                         vis_last;
    logic [eds_pkg::CYL_W-1:0]    seek_len;
    logic [eds_pkg::MOVE_W:0]     sum_wide;

    // Handshake and mode decode
    assign in_stall   = (state_reg != eds_pkg::ST_LOAD);
    assign accept     = in_valid && !in_stall;
    assign close      = accept && last_request;
    assign emit_ok    = !out_valid_reg || !out_stall;
    assign front_up   = stat.front_valid && !stat.front.down;
    assign mode_scan  = (sweep_mode == eds_pkg::MODE_SCAN);
    assign mode_cscan = (sweep_mode == eds_pkg::MODE_CSCAN);
    assign mode_look  = !mode_scan && !mode_cscan;

    // The first word of a batch supplies the start head
    assign head_eff = stat.front_valid ? start_head_reg : head_position;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eds_pkg::ST_LOAD:
            begin
                if (close)
                begin
                    state_next = eds_pkg::ST_UP;
                end
            end
            eds_pkg::ST_UP:
            begin
                if (front_up)
                begin
                    if (emit_ok && !stat.second_valid && mode_look)
                    begin
                        state_next = eds_pkg::ST_LOAD;
                    end
                end
                else
                begin
                    state_next = mode_look ? eds_pkg::ST_DOWN : eds_pkg::ST_TOP;
                end
            end
            eds_pkg::ST_TOP:
            begin
                if (emit_ok)
                begin
                    if (mode_cscan)
                    begin
                        state_next = eds_pkg::ST_BOTTOM;
                    end
                    else if (!stat.front_valid)
                    begin
                        state_next = eds_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = eds_pkg::ST_DOWN;
                    end
                end
            end
            eds_pkg::ST_BOTTOM:
            begin
                if (emit_ok)
                begin
                    state_next = stat.front_valid ? eds_pkg::ST_DOWN : eds_pkg::ST_LOAD;
                end
            end
            eds_pkg::ST_DOWN:
            begin
                if (!stat.front_valid)
                begin
                    state_next = eds_pkg::ST_LOAD;
                end
                else if (emit_ok && !stat.second_valid)
                begin
                    state_next = eds_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = eds_pkg::ST_LOAD;
            end
        endcase
    end

    // Chain command and visit selection
    always_comb
    begin
        cmd.op    = eds_pkg::OP_NONE;
        cmd.entry = '{down: (request_cylinder < head_eff), cyl: request_cylinder};
        emit      = 1'b0;
        vis_cyl   = stat.front.cyl;
        vis_end   = 1'b0;
        vis_last  = 1'b0;
        case (state_reg)
            eds_pkg::ST_LOAD:
            begin
                if (accept && !stat.full)
                begin
                    cmd.op = eds_pkg::OP_INSERT;
                end
            end
            eds_pkg::ST_UP:
            begin
                if (front_up && emit_ok)
                begin
                    cmd.op   = eds_pkg::OP_POP_FRONT;
                    emit     = 1'b1;
                    vis_last = !stat.second_valid && mode_look;
                end
            end
            eds_pkg::ST_TOP:
            begin
                if (emit_ok)
                begin
                    emit     = 1'b1;
                    vis_cyl  = top_cylinder;
                    vis_end  = 1'b1;
                    vis_last = mode_scan && !stat.front_valid;
                end
            end
            eds_pkg::ST_BOTTOM:
            begin
                if (emit_ok)
                begin
                    emit     = 1'b1;
                    vis_cyl  = bottom_cylinder;
                    vis_end  = 1'b1;
                    vis_last = !stat.front_valid;
                end
            end
            eds_pkg::ST_DOWN:
            begin
                if (stat.front_valid && emit_ok)
                begin
                    emit     = 1'b1;
                    vis_last = !stat.second_valid;
                    if (mode_cscan)
                    begin
                        cmd.op = eds_pkg::OP_POP_FRONT;
                    end
                    else
                    begin
                        cmd.op  = eds_pkg::OP_POP_BACK;
                        vis_cyl = stat.back.cyl;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Head movement, saturated at the field maximum
    always_comb
    begin
        seek_len      = (vis_cyl >= head_now_reg) ? (vis_cyl - head_now_reg)
                                                  : (head_now_reg - vis_cyl);
        sum_wide      = {1'b0, sum_reg} + (eds_pkg::MOVE_W+1)'(seek_len);
        head_now_next = head_now_reg;
        sum_next      = sum_reg;
        if (close)
        begin
            head_now_next = head_eff;
            sum_next      = '0;
        end
        else if (emit)
        begin
            head_now_next = vis_cyl;
            sum_next      = sum_wide[eds_pkg::MOVE_W] ? '1 : sum_wide[eds_pkg::MOVE_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eds_pkg::ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit || (out_valid_reg && out_stall);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        head_now_reg <= head_now_next;
        sum_reg      <= sum_next;
        if (accept && !stat.front_valid)
        begin
            start_head_reg <= head_position;
        end
        if (emit)
        begin
            out_cyl_reg  <= vis_cyl;
            out_sum_reg  <= sum_next;
            out_end_reg  <= vis_end;
            out_last_reg <= vis_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign visit_cylinder = out_cyl_reg;
    assign total_movement = out_sum_reg;
    assign is_endpoint    = out_end_reg;
    assign last_visit     = out_last_reg;

`ifndef SYNTHESIS
    // The final visit leaves the chain empty and returns to loading
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && vis_last) |=> (state_reg == eds_pkg::ST_LOAD && !stat.front_valid))
        else $error("chain not drained after final visit");

    // Only lower requests remain once the upward sweep is over
    a_down_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eds_pkg::ST_DOWN && stat.front_valid) |-> stat.front.down)
        else $error("upper request left in down sweep");

    // Movement never shrinks within a batch
    a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != eds_pkg::ST_LOAD && $past(state_reg) != eds_pkg::ST_LOAD)
            |-> (sum_reg >= $past(sum_reg)))
        else $error("movement sum decreased");
`endif

endmodule

`default_nettype wire

// File: sv/elevator_disk_request_scheduler.sv
// Top level of the elevator disk request scheduler with its configuration registers.
//
// Usage: the input channel takes one request word per cycle while loading
// (head_position, request_cylinder, last_request). head_position counts only
// on the first word of a batch; a word with last_request high closes the batch.
// Requests beyond the chain depth are dropped. Each word is inserted in sorted
// place by a row of MAX_REQUESTS cells. After the closing word, in_stall stays
// high while the visits go out on the output channel, one word per cycle while
// out_stall is low, each through the output register once the state register
// has left loading. Leaving the upward sweep for the turnaround or the downward
// sweep passes through ST_UP with no visit. A single output register holds a
// visit while out_stall is high and the sequence waits behind it.
// Configuration is written through cfg_write / cfg_index / cfg_data while the
// block is idle; the user must keep to this, as the block has no check for it.
// Reset empties the chain, clears the output valid and loads sweep mode SCAN,
// top cylinder 499 and bottom cylinder 0.
`default_nettype none

module elevator_disk_request_scheduler
#(
    parameter int MAX_REQUESTS = eds_pkg::MAX_REQUESTS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [eds_pkg::CYL_W-1:0]    head_position,
    input  wire logic [eds_pkg::CYL_W-1:0]    request_cylinder,
    input  wire logic                         last_request,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [eds_pkg::CYL_W-1:0]         visit_cylinder,
    output logic [eds_pkg::MOVE_W-1:0]        total_movement,
    output logic                              is_endpoint,
    output logic                              last_visit,
    input  wire logic                         cfg_write,
    input  wire logic [eds_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [eds_pkg::CFG_W-1:0]    cfg_data
);

    logic [eds_pkg::MODE_W-1:0] sweep_mode_reg;
    logic [eds_pkg::CYL_W-1:0]  top_cyl_reg;
    logic [eds_pkg::CYL_W-1:0]  bottom_cyl_reg;
    eds_pkg::chain_cmd_t        cmd;
    eds_pkg::chain_stat_t       stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_mode_reg <= eds_pkg::MODE_RESET;
            top_cyl_reg    <= eds_pkg::TOP_RESET;
            bottom_cyl_reg <= eds_pkg::BOTTOM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                eds_pkg::CFG_SWEEP_MODE:
                begin
                    sweep_mode_reg <= cfg_data[eds_pkg::MODE_W-1:0];
                end
                eds_pkg::CFG_TOP_CYLINDER:
                begin
                    top_cyl_reg <= cfg_data[eds_pkg::CYL_W-1:0];
                end
                eds_pkg::CFG_BOTTOM_CYLINDER:
                begin
                    bottom_cyl_reg <= cfg_data[eds_pkg::CYL_W-1:0];
                end
                default:
                begin
                    sweep_mode_reg <= sweep_mode_reg;
                end
            endcase
        end
    end

    eds_chain
    #(
        .MAX_REQUESTS (MAX_REQUESTS)
    )
    u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    eds_seq u_seq
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .head_position    (head_position),
        .request_cylinder (request_cylinder),
        .last_request     (last_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .visit_cylinder   (visit_cylinder),
        .total_movement   (total_movement),
        .is_endpoint      (is_endpoint),
        .last_visit       (last_visit),
        .sweep_mode       (sweep_mode_reg),
        .top_cylinder     (top_cyl_reg),
        .bottom_cylinder  (bottom_cyl_reg),
        .stat             (stat),
        .cmd              (cmd)
    );

endmodule

`default_nettype wire
